// ===== rtl/core/bf_pkg.sv =====
// ----------------------------------------------------------------------------
// bf_pkg
// Shared types and constants for the Blowfish cipher engine: item payloads,
// opcodes, register map and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package bf_pkg;

  // Default depth of the key byte store
  localparam int MAX_KEY_BYTES_DEF = 72;

  // Table geometry
  localparam int NUM_SUBKEYS = 18;
  localparam int TABLE_WORDS = 1042;
  localparam int NUM_SBOX    = 4;
  localparam int SBOX_DEPTH  = 256;

  // Sequencing limits
  localparam logic [3:0] LAST_ROUND  = 4'd15;
  localparam logic [4:0] LAST_SUBKEY = 5'd17;
  localparam logic [8:0] P_PAIR_LAST = 9'd8;
  localparam logic [8:0] S_PAIR_LAST = 9'd511;

  // Opcodes
  localparam logic [2:0] OP_WR_TABLE = 3'd0;
  localparam logic [2:0] OP_WR_KEY   = 3'd1;
  localparam logic [2:0] OP_EXPAND   = 3'd2;
  localparam logic [2:0] OP_DECRYPT  = 3'd3;
  localparam logic [2:0] OP_ENCRYPT  = 3'd4;

  // Register map: word index taken from paddr above the byte offset
  localparam int CFG_AW    = 3;
  localparam int REG_IDX_W = CFG_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = '0;

  // Input item
  typedef struct packed {
    logic [2:0]  opcode;
    logic [10:0] word_index;
    logic [31:0] table_word;
    logic [6:0]  key_index;
    logic [7:0]  key_byte;
    logic [31:0] left_block;
    logic [31:0] right_block;
  } bf_in_t;

  // Result item
  typedef struct packed {
    logic [31:0] left_result;
    logic [31:0] right_result;
    logic [2:0]  completed_op;
  } bf_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       acc;       // item transfer: latch block, apply table/key writes
    logic       rnd_a;     // round, first half: whiten left, issue S-box reads
    logic       rnd_f;     // round, second half: apply F and swap
    logic       fin;       // output whitening
    logic       dec;       // decrypt key order
    logic       kacc;      // shift a key byte into the key word
    logic       kxor;      // fold the key word into the addressed subkey
    logic       pwr;       // store block into a subkey pair
    logic       swr;       // store one block half into an S-box
    logic       swr_hi;    // which half: right when set
    logic [1:0] s_sel;     // S-box select for the store
    logic [7:0] s_addr;    // S-box entry for the store
    logic [4:0] p_idx;     // subkey index
    logic       load_out;  // load the result register
  } bf_cmd_t;

endpackage

// ===== rtl/core/bf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bf_ctrl
// Sequencer for the cipher engine: item intake, round counting, key schedule
// walk and result handoff. Drives the datapath through a command bundle.
// ----------------------------------------------------------------------------
module bf_ctrl
  import bf_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
  localparam int KAW = $clog2(MAX_KEY_BYTES),
  localparam int KLW = $clog2(MAX_KEY_BYTES + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [2:0]     in_opcode,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic [KLW-1:0] klen,
  output bf_cmd_t        cmd,
  output logic [KAW-1:0] key_addr
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_KRD  = 10'b00_0000_0010,
    S_KACC = 10'b00_0000_0100,
    S_RA   = 10'b00_0000_1000,
    S_RF   = 10'b00_0001_0000,
    S_FIN  = 10'b00_0010_0000,
    S_PWR  = 10'b00_0100_0000,
    S_SWL  = 10'b00_1000_0000,
    S_SWR  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_t;

  state_t         state_r, state_nxt;
  logic [3:0]     rnd_r, rnd_nxt;
  logic [4:0]     kw_r, kw_nxt;
  logic [1:0]     kb_r, kb_nxt;
  logic [KAW-1:0] j_r, j_nxt;
  logic [8:0]     pair_r, pair_nxt;
  logic           dec_r, dec_nxt;
  logic           exp_r, exp_nxt;
  logic           sph_r, sph_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [KLW-1:0] j_inc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign key_addr  = j_r;
  assign j_inc     = KLW'(j_r) + KLW'(1);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    kw_nxt    = kw_r;
    kb_nxt    = kb_r;
    j_nxt     = j_r;
    pair_nxt  = pair_r;
    dec_nxt   = dec_r;
    exp_nxt   = exp_r;
    sph_nxt   = sph_r;
    cmd       = '0;
    cmd.dec   = dec_r;
    cmd.s_sel = pair_r[8:7];
    cmd.s_addr = {pair_r[6:0], state_r == S_SWR};
    cmd.swr_hi = (state_r == S_SWR);

    // subkey index for the current step
    case (state_r)
      S_KACC:  cmd.p_idx = kw_r;
      S_PWR:   cmd.p_idx = {pair_r[3:0], 1'b0};
      default: cmd.p_idx = dec_r ? 5'(LAST_SUBKEY - {1'b0, rnd_r}) : {1'b0, rnd_r};
    endcase

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.acc = 1'b1;
          rnd_nxt = '0;
          case (in_opcode)
            OP_EXPAND: begin
              state_nxt = S_KRD;
              j_nxt     = '0;
              kw_nxt    = '0;
              kb_nxt    = '0;
              pair_nxt  = '0;
              sph_nxt   = 1'b0;
              exp_nxt   = 1'b1;
              dec_nxt   = 1'b0;
            end
            OP_DECRYPT: begin
              state_nxt = S_RA;
              exp_nxt   = 1'b0;
              dec_nxt   = 1'b1;
            end
            OP_ENCRYPT: begin
              state_nxt = S_RA;
              exp_nxt   = 1'b0;
              dec_nxt   = 1'b0;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_KRD: state_nxt = S_KACC;
      S_KACC: begin
        cmd.kacc = 1'b1;
        j_nxt    = (j_inc == klen) ? '0 : KAW'(j_inc);
        kb_nxt   = kb_r + 2'd1;
        state_nxt = S_KRD;
        if (kb_r == 2'd3) begin
          cmd.kxor = 1'b1;
          kw_nxt   = kw_r + 5'd1;
          if (kw_r == LAST_SUBKEY) begin
            rnd_nxt   = '0;
            state_nxt = S_RA;
          end
        end
      end
      S_RA: begin
        cmd.rnd_a = 1'b1;
        state_nxt = S_RF;
      end
      S_RF: begin
        cmd.rnd_f = 1'b1;
        rnd_nxt   = rnd_r + 4'd1;
        state_nxt = (rnd_r == LAST_ROUND) ? S_FIN : S_RA;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (!exp_r)
          state_nxt = S_DONE;
        else if (!sph_r)
          state_nxt = S_PWR;
        else
          state_nxt = S_SWL;
      end
      S_PWR: begin
        cmd.pwr   = 1'b1;
        state_nxt = S_RA;
        if (pair_r == P_PAIR_LAST) begin
          pair_nxt = '0;
          sph_nxt  = 1'b1;
        end else begin
          pair_nxt = pair_r + 9'd1;
        end
      end
      S_SWL: begin
        cmd.swr   = 1'b1;
        state_nxt = S_SWR;
      end
      S_SWR: begin
        cmd.swr = 1'b1;
        if (pair_r == S_PAIR_LAST) begin
          state_nxt = S_DONE;
        end else begin
          pair_nxt  = pair_r + 9'd1;
          state_nxt = S_RA;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid: set on load, cleared on transfer
  always_comb begin
    if (cmd.load_out)
      out_valid_nxt = 1'b1;
    else if (out_ready)
      out_valid_nxt = 1'b0;
    else
      out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rnd_r       <= '0;
      kw_r        <= '0;
      kb_r        <= '0;
      j_r         <= '0;
      pair_r      <= '0;
      dec_r       <= 1'b0;
      exp_r       <= 1'b0;
      sph_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rnd_r       <= rnd_nxt;
      kw_r        <= kw_nxt;
      kb_r        <= kb_nxt;
      j_r         <= j_nxt;
      pair_r      <= pair_nxt;
      dec_r       <= dec_nxt;
      exp_r       <= exp_nxt;
      sph_r       <= sph_nxt;
    end
  end

endmodule

// ===== rtl/core/bf_dp.sv =====
// ----------------------------------------------------------------------------
// bf_dp
// Cipher datapath: subkey registers, four S-box memories, key byte memory,
// the running block halves, the round function and the result register.
// ----------------------------------------------------------------------------
module bf_dp
  import bf_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
  localparam int KAW = $clog2(MAX_KEY_BYTES)
) (
  input  logic           clk,
  input  bf_in_t         in_data,
  input  bf_cmd_t        cmd,
  input  logic [KAW-1:0] key_addr,
  output bf_out_t        out_data
);

  logic [31:0]    p_r [NUM_SUBKEYS];
  logic [31:0]    l_r, r_r;
  logic [2:0]     op_r;
  logic [23:0]    k_r;
  logic [7:0]     kd_r;
  logic [31:0]    sd_r [NUM_SBOX];
  logic [7:0]     key_mem [MAX_KEY_BYTES];
  bf_out_t        out_r;

  logic [31:0]    p_rd;
  logic [31:0]    lx;
  logic [31:0]    f_val;
  logic [31:0]    kword;
  logic           tbl_p_we;
  logic           tbl_s_we;
  logic [10:0]    s_off;
  logic [1:0]     tsel;
  logic [7:0]     taddr;
  logic           key_we;
  logic [4:0]     p_idx_hi;

  assign p_rd     = p_r[cmd.p_idx];
  assign p_idx_hi = cmd.p_idx + 5'd1;
  assign lx       = l_r ^ p_rd;
  assign f_val    = ((sd_r[0] + sd_r[1]) ^ sd_r[2]) + sd_r[3];
  assign kword    = {k_r, kd_r};

  // Decode of table and key writes carried by an item
  assign tbl_p_we = cmd.acc && (in_data.opcode == OP_WR_TABLE) &&
                    (in_data.word_index < 11'(NUM_SUBKEYS));
  assign tbl_s_we = cmd.acc && (in_data.opcode == OP_WR_TABLE) &&
                    (in_data.word_index >= 11'(NUM_SUBKEYS)) &&
                    (in_data.word_index < 11'(TABLE_WORDS));
  assign s_off    = in_data.word_index - 11'(NUM_SUBKEYS);
  assign tsel     = s_off[9:8];
  assign taddr    = s_off[7:0];
  assign key_we   = cmd.acc && (in_data.opcode == OP_WR_KEY) &&
                    (in_data.key_index < 7'(MAX_KEY_BYTES));

  // Subkey registers
  always_ff @(posedge clk) begin
    if (tbl_p_we)
      p_r[in_data.word_index[4:0]] <= in_data.table_word;
    if (cmd.kxor)
      p_r[cmd.p_idx] <= p_rd ^ kword;
    if (cmd.pwr) begin
      p_r[cmd.p_idx] <= l_r;
      p_r[p_idx_hi]  <= r_r;
    end
  end

  // Running block halves
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      op_r <= in_data.opcode;
      if (in_data.opcode == OP_EXPAND) begin
        l_r <= '0;
        r_r <= '0;
      end else begin
        l_r <= in_data.left_block;
        r_r <= in_data.right_block;
      end
    end else if (cmd.rnd_a) begin
      l_r <= lx;
    end else if (cmd.rnd_f) begin
      l_r <= r_r ^ f_val;
      r_r <= l_r;
    end else if (cmd.fin) begin
      l_r <= r_r ^ (cmd.dec ? p_r[0] : p_r[17]);
      r_r <= l_r ^ (cmd.dec ? p_r[1] : p_r[16]);
    end
  end

  // Key byte memory and key word assembly
  always_ff @(posedge clk) begin
    if (key_we)
      key_mem[in_data.key_index[KAW-1:0]] <= in_data.key_byte;
    kd_r <= key_mem[key_addr];
    if (cmd.kacc)
      k_r <= kword[23:0];
  end

  // S-box memories: one write and one registered read each
  for (genvar g = 0; g < NUM_SBOX; g++) begin : g_sbox
    logic [31:0] mem [SBOX_DEPTH];
    logic        we;
    logic [7:0]  waddr;
    logic [31:0] wdata;

    assign we    = (tbl_s_we && (tsel == 2'(g))) || (cmd.swr && (cmd.s_sel == 2'(g)));
    assign waddr = cmd.swr ? cmd.s_addr : taddr;
    assign wdata = cmd.swr ? (cmd.swr_hi ? r_r : l_r) : in_data.table_word;

    always_ff @(posedge clk) begin
      if (we)
        mem[waddr] <= wdata;
      sd_r[g] <= mem[lx[31-8*g -: 8]];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if ((op_r == OP_DECRYPT) || (op_r == OP_ENCRYPT)) begin
        out_r.left_result  <= l_r;
        out_r.right_result <= r_r;
      end else begin
        out_r.left_result  <= '0;
        out_r.right_result <= '0;
      end
      out_r.completed_op <= op_r;
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/core/blowfish_block_cipher.sv =====
// ----------------------------------------------------------------------------
// blowfish_block_cipher
// Blowfish engine with table and key loading, key schedule and block
// encrypt/decrypt. Control register key_length on an APB-style port.
// ----------------------------------------------------------------------------
// Sequence: table/key write and unused opcodes pass from the transfer through
//   S_DONE to the result register; encrypt/decrypt run 16 rounds of S_RA and
//   S_RF (split by the registered S-box read), then whitening and result load.
// Items: a new one is taken only in S_IDLE, once the last result is loaded;
//   key schedule folds the key into 18 subkeys, then 521 encryptions and stores.
// Reset: control and key_length (to 1) cleared; tables and key undefined.
// ----------------------------------------------------------------------------
module blowfish_block_cipher
  import bf_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  bf_in_t            in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output bf_out_t           out_data,
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int KAW = $clog2(MAX_KEY_BYTES);
  localparam int KLW = $clog2(MAX_KEY_BYTES + 1);

  logic [6:0]     key_length_r;
  logic           cfg_sel_kl;
  logic           cfg_we;
  logic [KLW-1:0] klen;
  bf_cmd_t        cmd;
  logic [KAW-1:0] key_addr;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_sel_kl = (cfg_paddr[CFG_AW-1:2] == REG_KEY_LENGTH);
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_kl;
  assign cfg_prdata = cfg_sel_kl ? {25'd0, key_length_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n)
      key_length_r <= 7'd1;
    else if (cfg_we)
      key_length_r <= cfg_pwdata[6:0];
  end

  // Effective key length: zero reads as one, saturate at store depth
  always_comb begin
    if (key_length_r == 7'd0)
      klen = KLW'(1);
    else if (key_length_r > 7'(MAX_KEY_BYTES))
      klen = KLW'(MAX_KEY_BYTES);
    else
      klen = KLW'(key_length_r);
  end

  bf_ctrl #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .klen      (klen),
    .cmd       (cmd),
    .key_addr  (key_addr)
  );

  bf_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .key_addr (key_addr),
    .out_data (out_data)
  );

endmodule
